@@ rtl/xidr_pkg.sv @@
// Shared types and constants of the XID discovery responder.
package xidr_pkg;

    localparam int MIN_FRAME_BYTES = 12;
    localparam int MAX_FRAME_BYTES = 44;
    localparam int MAX_SLOTS       = 16;

    localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CD_W      = 20;
    localparam int RND_W     = 8;
    localparam int DIV_CNT_W = $clog2(RND_W);
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [7:0]  XID_FORMAT   = 8'h01;
    localparam logic [7:0]  XID_VERSION  = 8'h00;
    localparam logic [31:0] ADDR_BCAST   = 32'hFFFF_FFFF;
    localparam logic [31:0] ADDR_NULL    = 32'h0000_0000;
    localparam logic [7:0]  SLOT_FINAL   = 8'hFF;
    localparam int          FLAG_NEWADDR = 2;

    localparam logic [31:0] OWN_ADDR_RST   = 32'd1;
    localparam logic [15:0] SLOT_TICKS_RST = 16'd50;

    localparam logic [COUNT_W-1:0] SLOT_COUNTS [4] = '{
        COUNT_W'(1), COUNT_W'(6), COUNT_W'(8), COUNT_W'(MAX_SLOTS)
    };

    typedef enum logic [2:0] {
        EV_IGNORED = 3'd0,
        EV_INVALID = 3'd1,
        EV_ARMED   = 3'd2,
        EV_RESP    = 3'd3,
        EV_IND     = 3'd4,
        EV_TIMEOUT = 3'd5
    } t_event;

    typedef enum logic [0:0] {
        REG_OWN_ADDR   = 1'b0,
        REG_SLOT_TICKS = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_ARM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_len;
        logic [7:0]  format_id;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  disc_flags;
        logic [7:0]  slot_number;
        logic [7:0]  version;
        logic [7:0]  random_value;
    } t_req;

    typedef struct packed {
        t_event      event_res;
        logic [31:0] resp_dst_address;
        logic [2:0]  resp_flags;
        logic [3:0]  resp_slot;
        logic [31:0] peer_address;
        logic [7:0]  peer_version;
        logic [5:0]  info_len;
        logic        new_address_request;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic arm;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/xidr_chan_if.sv @@
// Request and result channel interfaces.
interface xidr_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  frame_len;
    logic [7:0]  format_id;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  disc_flags;
    logic [7:0]  slot_number;
    logic [7:0]  version;
    logic [7:0]  random_value;

    modport source (
        output valid, kind, frame_len, format_id, src_addr, dst_addr,
               disc_flags, slot_number, version, random_value,
        input  ready
    );
    modport sink (
        input  valid, kind, frame_len, format_id, src_addr, dst_addr,
               disc_flags, slot_number, version, random_value,
        output ready
    );
endinterface

interface xidr_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [31:0] resp_dst_address;
    logic [2:0]  resp_flags;
    logic [3:0]  resp_slot;
    logic [31:0] peer_address;
    logic [7:0]  peer_version;
    logic [5:0]  info_len;
    logic        new_address_request;

    modport source (
        output valid, event_res, resp_dst_address, resp_flags, resp_slot,
               peer_address, peer_version, info_len, new_address_request,
        input  ready
    );
    modport sink (
        input  valid, event_res, resp_dst_address, resp_flags, resp_slot,
               peer_address, peer_version, info_len, new_address_request,
        output ready
    );
endinterface

@@ rtl/xidr_cfg.sv @@
// APB configuration registers: own address and slot period.
module xidr_cfg
    import xidr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [31:0]       o_own_address,
    output logic [15:0]       o_slot_ticks
);

    logic [31:0] r_own_address;
    logic [15:0] r_slot_ticks;
    t_reg_idx    w_idx;
    logic        w_wr;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= OWN_ADDR_RST;
            r_slot_ticks  <= SLOT_TICKS_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_OWN_ADDR:   r_own_address <= pwdata;
                REG_SLOT_TICKS: r_slot_ticks  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_OWN_ADDR:   prdata = r_own_address;
            REG_SLOT_TICKS: prdata = {16'b0, r_slot_ticks};
            default:        prdata = '0;
        endcase
    end

    assign o_own_address = r_own_address;
    assign o_slot_ticks  = r_slot_ticks;

endmodule

@@ rtl/xidr_ctrl.sv @@
// Sequencing state machine of the discovery responder.
module xidr_ctrl
    import xidr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_EVAL;
            ST_EVAL: n_state = i_sts.need_div ? ST_DIV : ST_DONE;
            ST_DIV:  if (i_sts.div_last) n_state = ST_ARM;
            ST_ARM:  n_state = ST_DONE;
            ST_DONE: if (i_sts.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EVAL: o_cmd.eval     = 1'b1;
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_ARM:  o_cmd.arm      = 1'b1;
            ST_DONE: o_cmd.load_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

@@ rtl/xidr_dp.sv @@
// Datapath: frame checks, reply state, slot remainder unit and result register.
module xidr_dp
    import xidr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_req        i_req,
    input  logic [31:0] i_own_address,
    input  logic [15:0] i_slot_ticks,
    input  logic        i_out_ready,
    output t_sts        o_sts,
    output t_rsp        o_rsp,
    output logic        o_out_valid
);

    t_req                 r_item;
    t_rsp                 r_res;
    t_rsp                 r_out;
    logic                 r_out_valid;
    logic                 r_reply_mode;
    logic [SLOT_W-1:0]    r_chosen_slot;
    logic                 r_response_sent;
    logic [CD_W-1:0]      r_countdown;
    logic [COUNT_W-1:0]   r_span;
    logic [SLOT_W-1:0]    r_rem;
    logic [RND_W-1:0]     r_dvd;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    t_rsp                 n_res;
    logic                 n_reply_mode;
    logic                 n_response_sent;
    logic [CD_W-1:0]      n_countdown;
    logic                 w_need_div;

    t_rsp                 a_res;
    logic                 a_sent;
    logic [SLOT_W-1:0]    a_chosen;
    logic [CD_W+COUNT_W-1:0] w_prod;

    logic [COUNT_W-1:0]   w_count;
    logic                 w_bad;
    logic                 w_for_us;
    logic                 w_final;
    logic                 w_range_bad;
    logic [SLOT_W:0]      w_trial;

    assign w_count  = SLOT_COUNTS[r_item.disc_flags[1:0]];
    assign w_bad    = (r_item.frame_len < 8'(MIN_FRAME_BYTES))
                   || (r_item.frame_len > 8'(MAX_FRAME_BYTES))
                   || (r_item.format_id != XID_FORMAT)
                   || (r_item.version != XID_VERSION)
                   || (r_item.src_addr == ADDR_NULL)
                   || (r_item.src_addr == ADDR_BCAST);
    assign w_for_us = (r_item.dst_addr == ADDR_BCAST)
                   || (r_item.dst_addr == i_own_address);
    assign w_final  = (r_item.slot_number == SLOT_FINAL);
    assign w_range_bad = (r_item.slot_number >= 8'(w_count)) && !w_final;

    // decision for everything that needs no slot choice
    always_comb begin
        n_res           = '0;
        n_res.event_res = EV_IGNORED;
        n_reply_mode    = r_reply_mode;
        n_response_sent = r_response_sent;
        n_countdown     = r_countdown;
        w_need_div      = 1'b0;
        if (r_item.kind) begin
            if (r_reply_mode) begin
                if (r_countdown <= CD_W'(1)) begin
                    n_countdown     = '0;
                    n_reply_mode    = 1'b0;
                    n_res.event_res = EV_TIMEOUT;
                end else begin
                    n_countdown = r_countdown - CD_W'(1);
                end
            end
        end else if (w_bad) begin
            n_res.event_res = EV_INVALID;
        end else if (!w_for_us) begin
            n_res.event_res = EV_IGNORED;
        end else if (w_range_bad) begin
            n_res.event_res = EV_INVALID;
        end else if (!r_reply_mode) begin
            w_need_div = !w_final;
        end else if (w_final) begin
            n_countdown        = '0;
            n_reply_mode       = 1'b0;
            n_res.event_res    = EV_IND;
            n_res.peer_address = r_item.src_addr;
            n_res.peer_version = r_item.version;
            n_res.info_len     = 6'(r_item.frame_len - 8'(MIN_FRAME_BYTES));
        end else if (!r_response_sent
                     && (r_item.slot_number >= 8'(r_chosen_slot))) begin
            n_res.event_res        = EV_RESP;
            n_res.resp_dst_address = r_item.src_addr;
            n_res.resp_flags       = r_item.disc_flags[2:0];
            n_res.resp_slot        = r_item.slot_number[3:0];
            n_response_sent        = 1'b1;
        end
    end

    // arming a new round once the remainder is known
    assign a_chosen = r_item.slot_number[SLOT_W-1:0] + r_rem;
    assign w_prod   = (CD_W+COUNT_W)'(i_slot_ticks) * (CD_W+COUNT_W)'(r_span);

    always_comb begin
        a_res                     = '0;
        a_res.new_address_request = r_item.disc_flags[FLAG_NEWADDR];
        a_sent                    = 1'b0;
        if (r_item.slot_number[SLOT_W-1:0] == a_chosen) begin
            a_res.event_res        = EV_RESP;
            a_res.resp_dst_address = r_item.src_addr;
            a_res.resp_flags       = r_item.disc_flags[2:0];
            a_res.resp_slot        = r_item.slot_number[3:0];
            a_sent                 = 1'b1;
        end else begin
            a_res.event_res = EV_ARMED;
        end
    end

    assign w_trial = {r_rem, r_dvd[RND_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_req;
        end
        if (i_cmd.eval) begin
            r_res   <= n_res;
            r_span  <= COUNT_W'(w_count - COUNT_W'(r_item.slot_number[SLOT_W-1:0]));
            r_rem   <= '0;
            r_dvd   <= r_item.random_value;
        end else if (i_cmd.div_step) begin
            if (w_trial >= (SLOT_W+1)'(r_span)) begin
                r_rem <= SLOT_W'(w_trial - (SLOT_W+1)'(r_span));
            end else begin
                r_rem <= w_trial[SLOT_W-1:0];
            end
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
        end else if (i_cmd.arm) begin
            r_res <= a_res;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_reply_mode    <= 1'b0;
            r_chosen_slot   <= '0;
            r_response_sent <= 1'b0;
            r_countdown     <= '0;
            r_div_cnt       <= '0;
        end else begin
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.eval) begin
                r_reply_mode    <= n_reply_mode;
                r_response_sent <= n_response_sent;
                r_countdown     <= n_countdown;
                r_div_cnt       <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end else if (i_cmd.arm) begin
                r_reply_mode    <= 1'b1;
                r_chosen_slot   <= a_chosen;
                r_response_sent <= a_sent;
                r_countdown     <= w_prod[CD_W-1:0];
            end
        end
    end

    assign o_sts.need_div = w_need_div;
    assign o_sts.div_last = (r_div_cnt == DIV_CNT_W'(RND_W - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_rsp          = r_out;
    assign o_out_valid    = r_out_valid;

endmodule

@@ rtl/xid_discovery_responder_core.sv @@
// Top level of the XID discovery responder.
//
//   channel  direction  handshake      payload
//   i_req    in         valid/ready    frame fields or timer tick
//   o_rsp    out        valid/ready    one result per item
//   apb      in         psel/penable   own_address (0x0), slot_timeout_ticks (0x4)
//
// A tick or a frame that arms no reply passes through the EVAL and DONE states
// before the next item is accepted; a frame that arms a reply also passes through
// the 8-step remainder unit for the slot choice (DIV) and the arming state (ARM).
// The result register lets the next item in while a result is still held.
// Reset is synchronous and clears all control and discovery state.
module xid_discovery_responder_core
    import xidr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    xidr_req_if.sink          i_req,
    xidr_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [31:0] w_own_address;
    logic [15:0] w_slot_ticks;
    t_cmd        w_cmd;
    t_sts        w_sts;
    t_req        w_req;
    t_rsp        w_rsp;
    logic        w_in_ready;
    logic        w_out_valid;

    assign w_req.kind         = i_req.kind;
    assign w_req.frame_len    = i_req.frame_len;
    assign w_req.format_id    = i_req.format_id;
    assign w_req.src_addr     = i_req.src_addr;
    assign w_req.dst_addr     = i_req.dst_addr;
    assign w_req.disc_flags   = i_req.disc_flags;
    assign w_req.slot_number  = i_req.slot_number;
    assign w_req.version      = i_req.version;
    assign w_req.random_value = i_req.random_value;

    xidr_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_own_address (w_own_address),
        .o_slot_ticks  (w_slot_ticks)
    );

    xidr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    xidr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req         (w_req),
        .i_own_address (w_own_address),
        .i_slot_ticks  (w_slot_ticks),
        .i_out_ready   (o_rsp.ready),
        .o_sts         (w_sts),
        .o_rsp         (w_rsp),
        .o_out_valid   (w_out_valid)
    );

    assign i_req.ready               = w_in_ready;
    assign o_rsp.valid               = w_out_valid;
    assign o_rsp.event_res           = w_rsp.event_res;
    assign o_rsp.resp_dst_address    = w_rsp.resp_dst_address;
    assign o_rsp.resp_flags          = w_rsp.resp_flags;
    assign o_rsp.resp_slot           = w_rsp.resp_slot;
    assign o_rsp.peer_address        = w_rsp.peer_address;
    assign o_rsp.peer_version        = w_rsp.peer_version;
    assign o_rsp.info_len            = w_rsp.info_len;
    assign o_rsp.new_address_request = w_rsp.new_address_request;

endmodule

@@ rtl/xidr_chk.sv @@
// Port-level checker for the discovery responder, bound to the top level.
module xidr_chk
    import xidr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_event_res,
    input logic [31:0] i_resp_dst_address,
    input logic [2:0]  i_resp_flags,
    input logic [3:0]  i_resp_slot
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one item in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while busy");

    a_resp_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_res != EV_RESP) |->
            (i_resp_dst_address == '0) && (i_resp_flags == '0) && (i_resp_slot == '0))
        else $error("response fields set on non-response event");

endmodule

bind xid_discovery_responder_core xidr_chk u_xidr_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_req.valid),
    .i_in_ready         (i_req.ready),
    .i_out_valid        (o_rsp.valid),
    .i_out_ready        (o_rsp.ready),
    .i_event_res        (o_rsp.event_res),
    .i_resp_dst_address (o_rsp.resp_dst_address),
    .i_resp_flags       (o_rsp.resp_flags),
    .i_resp_slot        (o_rsp.resp_slot)
);
